>>> sv/rcg_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the reference-counted module clock gate.
// Depends on nothing; used by every module of the block.
package rcg_pkg;

  localparam int NUM_REGS_DEF     = 5;
  localparam int BITS_PER_REG_DEF = 32;

  localparam int STOP_W  = 32;
  localparam int BIT_W   = 5;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 8;
  localparam int ID_W    = 16;
  localparam int QDEPTH  = 2;

  localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENABLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_ID    = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_STATE = 2'd2;

  localparam logic [STOP_W-1:0] WORD0_RESET = 32'hFFFF_FFF0;
  localparam logic [STOP_W-1:0] WORD_RESET  = 32'hFFFF_FFFF;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

endpackage

>>> sv/rcg_front.sv
`timescale 1ns / 1ps
// Request front end: accepts a beat, checks the module id and packs a queue entry.
// Depends on rcg_pkg.
module rcg_front #(
  parameter int NUM_REGS     = rcg_pkg::NUM_REGS_DEF,
  parameter int BITS_PER_REG = rcg_pkg::BITS_PER_REG_DEF,
  parameter int ENTRY_W      = 16
) (
  input  logic                     start_i,
  input  logic                     full_i,
  input  logic                     clear_done_i,
  input  logic [rcg_pkg::OP_W-1:0] operation_i,
  input  logic [rcg_pkg::ID_W-1:0] id_i,
  output logic                     busy_o,
  output logic                     push_o,
  output logic [ENTRY_W-1:0]       entry_o
);
  import rcg_pkg::*;

  localparam int DEPTH = NUM_REGS * BITS_PER_REG;
  localparam int REG_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       reg_sel;
  logic [7:0]       bit_sel;
  logic             bad_id;
  logic [15:0]      flat_idx;
  logic [REG_W-1:0] reg_f;
  logic [BIT_W-1:0] bit_f;
  logic [IDX_W-1:0] idx_f;

  assign reg_sel  = id_i[15:8];
  assign bit_sel  = id_i[7:0];
  assign bad_id   = (reg_sel >= 8'(NUM_REGS)) || (bit_sel >= 8'(BITS_PER_REG));
  assign flat_idx = ({8'd0, reg_sel} * 16'(BITS_PER_REG)) + {8'd0, bit_sel};

  assign reg_f = bad_id ? '0 : REG_W'(reg_sel);
  assign bit_f = bad_id ? '0 : BIT_W'(bit_sel);
  assign idx_f = bad_id ? '0 : IDX_W'(flat_idx);

  assign busy_o  = full_i || !clear_done_i;
  assign push_o  = start_i && !busy_o;
  assign entry_o = {bad_id, operation_i, reg_f, bit_f, idx_f};

endmodule

>>> sv/rcg_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the request front end and the execution back end.
// Depends on rcg_pkg for its depth.
module rcg_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  import rcg_pkg::*;

  logic [WIDTH-1:0] ent_q [QDEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'(QDEPTH));
  assign rdata_o = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/rcg_back.sv
`timescale 1ns / 1ps
// Execution back end: use-count memory, stop words and the result registers.
// Depends on rcg_pkg.
module rcg_back #(
  parameter int NUM_REGS     = rcg_pkg::NUM_REGS_DEF,
  parameter int BITS_PER_REG = rcg_pkg::BITS_PER_REG_DEF,
  parameter int ENTRY_W      = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  logic [ENTRY_W-1:0]         entry_i,
  output logic                       pop_o,
  output logic                       clear_done_o,
  output logic                       done_o,
  output logic [rcg_pkg::ST_W-1:0]   status_o,
  output logic [rcg_pkg::CNT_W-1:0]  use_count_o,
  output logic                       stopped_o,
  output logic [rcg_pkg::STOP_W-1:0] stop_word_o
);
  import rcg_pkg::*;

  localparam int DEPTH = NUM_REGS * BITS_PER_REG;
  localparam int REG_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [ENTRY_W-1:0] ent_q, ent_d;
  logic [CNT_W-1:0]   mem [DEPTH];
  logic [CNT_W-1:0]   rdata_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  logic [CNT_W-1:0]   mem_wdata;
  logic [STOP_W-1:0]  stop_q [NUM_REGS];
  logic               stop_we;

  logic               e_bad;
  logic [OP_W-1:0]    e_op;
  logic [REG_W-1:0]   e_reg;
  logic [BIT_W-1:0]   e_bit;
  logic [IDX_W-1:0]   e_idx;
  logic [IDX_W-1:0]   in_idx;
  logic [STOP_W-1:0]  mask;
  logic [STOP_W-1:0]  word_cur, word_new;
  logic [CNT_W-1:0]   cnt_new;
  logic [ST_W-1:0]    st_new;
  logic               upd;

  logic               done_d;
  logic [ST_W-1:0]    status_d;
  logic [CNT_W-1:0]   use_count_d;
  logic               stopped_d;
  logic [STOP_W-1:0]  stop_word_d;

  assign {e_bad, e_op, e_reg, e_bit, e_idx} = ent_q;
  assign in_idx       = entry_i[IDX_W-1:0];
  assign clear_done_o = (state_q != S_CLEAR);
  assign mask         = STOP_W'(1) << e_bit;
  assign word_cur     = stop_q[e_reg];

  always_comb begin
    cnt_new  = rdata_q;
    word_new = word_cur;
    st_new   = ST_OK;
    upd      = 1'b0;
    if (e_op == OP_ENABLE) begin
      if (rdata_q == CNT_MAX) begin
        st_new = ST_BAD_STATE;
      end else begin
        upd     = 1'b1;
        cnt_new = rdata_q + CNT_W'(1);
        if (rdata_q == '0) begin
          word_new = word_cur & ~mask;
        end
      end
    end else if (e_op == OP_DISABLE) begin
      if (rdata_q == '0) begin
        st_new = ST_BAD_STATE;
      end else begin
        upd     = 1'b1;
        cnt_new = rdata_q - CNT_W'(1);
        if (rdata_q == CNT_W'(1)) begin
          word_new = word_cur | mask;
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ent_d       = ent_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = e_idx;
    mem_wdata   = cnt_new;
    stop_we     = 1'b0;
    done_d      = 1'b0;
    status_d    = status_o;
    use_count_d = use_count_o;
    stopped_d   = stopped_o;
    stop_word_d = stop_word_o;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == IDX_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          mem_re  = 1'b1;
          ent_d   = entry_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (e_bad) begin
          status_d    = ST_BAD_ID;
          use_count_d = '0;
          stopped_d   = 1'b0;
          stop_word_d = '0;
        end else begin
          mem_we      = upd;
          stop_we     = upd;
          status_d    = st_new;
          use_count_d = cnt_new;
          stopped_d   = |(word_new & mask);
          stop_word_d = word_new;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_o  <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        stop_q[i] <= (i == 0) ? WORD0_RESET : WORD_RESET;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_o  <= done_d;
      if (stop_we) begin
        stop_q[e_reg] <= word_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q       <= ent_d;
    status_o    <= status_d;
    use_count_o <= use_count_d;
    stopped_o   <= stopped_d;
    stop_word_o <= stop_word_d;
  end

endmodule

>>> sv/refcounted_module_clock_gate.sv
`timescale 1ns / 1ps
// Top level of the reference-counted module clock gate.
// Depends on rcg_pkg, rcg_front, rcg_queue and rcg_back.
//
// A request beat is taken when start is high and busy is low. Every request
// yields exactly one result, shown for one cycle with done_o high; the receiver
// cannot stall it. A taken request is written into the queue; the back end then
// pops it and reads the use count of its slot, then updates the memory and
// registers the result. Requests still queued ahead of it delay its result.
// The back end handles one request at a time, reading the use-count memory in
// its idle state and writing it back in its execute state, and a two-entry
// queue lets a request be taken while an earlier one executes. After reset the
// block stays busy while it clears all NUM_REGS * BITS_PER_REG (160 by default)
// entries of the use-count memory.
module refcounted_module_clock_gate #(
  parameter int NUM_REGS     = rcg_pkg::NUM_REGS_DEF,
  parameter int BITS_PER_REG = rcg_pkg::BITS_PER_REG_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [rcg_pkg::OP_W-1:0]   operation_i,
  input  logic [rcg_pkg::ID_W-1:0]   id_i,
  output logic                       done_o,
  output logic [rcg_pkg::ST_W-1:0]   status_o,
  output logic [rcg_pkg::CNT_W-1:0]  use_count_o,
  output logic                       stopped_o,
  output logic [rcg_pkg::STOP_W-1:0] stop_word_o
);
  import rcg_pkg::*;

  localparam int DEPTH   = NUM_REGS * BITS_PER_REG;
  localparam int REG_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = 1 + OP_W + REG_W + BIT_W + IDX_W;

  logic               push, pop, full, empty, clear_done;
  logic [ENTRY_W-1:0] push_entry, head_entry;

  rcg_front #(
    .NUM_REGS     (NUM_REGS),
    .BITS_PER_REG (BITS_PER_REG),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .start_i      (start),
    .full_i       (full),
    .clear_done_i (clear_done),
    .operation_i  (operation_i),
    .id_i         (id_i),
    .busy_o       (busy),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  rcg_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  rcg_back #(
    .NUM_REGS     (NUM_REGS),
    .BITS_PER_REG (BITS_PER_REG),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .clear_done_o (clear_done),
    .done_o       (done_o),
    .status_o     (status_o),
    .use_count_o  (use_count_o),
    .stopped_o    (stopped_o),
    .stop_word_o  (stop_word_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_module_clock_gate: a directed pass,
// a count saturation pass and random request traffic at three idle rates.
// Depends on rcg_pkg and the refcounted_module_clock_gate RTL.
module tb_top;
  import rcg_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int NUM_SLOTS = NUM_REGS_DEF * BITS_PER_REG_DEF;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  use_count;
    logic              stopped;
    logic [STOP_W-1:0] stop_word;
  } gate_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   operation_i;
  logic [ID_W-1:0]   id_i;
  logic              done_o;
  logic [ST_W-1:0]   status_o;
  logic [CNT_W-1:0]  use_count_o;
  logic              stopped_o;
  logic [STOP_W-1:0] stop_word_o;

  logic [CNT_W-1:0]  model_counts [NUM_SLOTS];
  logic [STOP_W-1:0] model_stop_words [NUM_REGS_DEF];
  gate_result_t      pending_results [$];

  int idle_pct = 0;
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int n_ok = 0;
  int n_bad_id = 0;
  int n_bad_state = 0;
  int quiet_cycles = 0;

  refcounted_module_clock_gate i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .id_i        (id_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .use_count_o (use_count_o),
    .stopped_o   (stopped_o),
    .stop_word_o (stop_word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic gate_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [ID_W-1:0] id);
    logic [7:0]        word_idx;
    logic [7:0]        bit_pos;
    int                slot;
    logic [STOP_W-1:0] mask;
    logic [CNT_W-1:0]  cnt;
    gate_result_t      r;
    word_idx = id[15:8];
    bit_pos  = id[7:0];
    r = '0;
    if (word_idx >= NUM_REGS_DEF || bit_pos >= BITS_PER_REG_DEF) begin
      r.status = ST_BAD_ID;
      return r;
    end
    slot = int'(word_idx) * BITS_PER_REG_DEF + int'(bit_pos);
    mask = 32'd1 << bit_pos;
    cnt  = model_counts[slot];
    r.status = ST_OK;
    if (op == OP_ENABLE) begin
      if (cnt == CNT_MAX) begin
        r.status = ST_BAD_STATE;
      end else begin
        if (cnt == '0) model_stop_words[word_idx] &= ~mask;
        cnt = cnt + 8'd1;
        model_counts[slot] = cnt;
      end
    end else if (op == OP_DISABLE) begin
      if (cnt == '0) begin
        r.status = ST_BAD_STATE;
      end else begin
        if (cnt == 8'd1) model_stop_words[word_idx] |= mask;
        cnt = cnt - 8'd1;
        model_counts[slot] = cnt;
      end
    end
    r.use_count = cnt;
    r.stopped   = |(model_stop_words[word_idx] & mask);
    r.stop_word = model_stop_words[word_idx];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 50) begin
      $display("MISMATCH at result beat %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    end
    errors++;
  endtask

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    start <= 1'b1;
    operation_i <= op;
    id_i <= id;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(apply_request(op, id));
    beats_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    send_beat(OP_QUERY, 16'h0000);
    send_beat(OP_QUERY, 16'h041F);
    send_beat(OP_DISABLE, 16'h0000);
    send_beat(OP_ENABLE, 16'h0000);
    send_beat(OP_DISABLE, 16'h0000);
    send_beat(OP_ENABLE, 16'h041F);
    send_beat(OP_ENABLE, 16'h041F);
    send_beat(OP_DISABLE, 16'h041F);
    send_beat(OP_DISABLE, 16'h041F);
    send_beat(OP_ENABLE, 16'h0105);
    send_beat(OP_UNUSED, 16'h0105);
    send_beat(OP_QUERY, 16'h0500);
    send_beat(OP_ENABLE, 16'h0020);
    send_beat(OP_DISABLE, 16'hFFFF);
    send_beat(OP_QUERY, 16'h00FF);
    send_beat(OP_UNUSED, 16'hFF00);
    send_beat(OP_ENABLE, 16'h0420);
    send_beat(OP_DISABLE, 16'h0105);
    send_beat(OP_ENABLE, 16'h0003);
    send_beat(OP_DISABLE, 16'h0003);
  endtask

  task automatic test_saturation();
    logic [ID_W-1:0] id;
    id = {8'($urandom_range(0, NUM_REGS_DEF - 1)),
          8'($urandom_range(0, BITS_PER_REG_DEF - 1))};
    repeat (256) send_beat(OP_ENABLE, id);
    send_beat(OP_QUERY, id);
    repeat (256) send_beat(OP_DISABLE, id);
  endtask

  task automatic test_random_traffic(input int n_beats);
    logic [ID_W-1:0] pool [6];
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    int              pick;
    foreach (pool[k]) begin
      pool[k] = {8'($urandom_range(0, NUM_REGS_DEF - 1)),
                 8'($urandom_range(0, BITS_PER_REG_DEF - 1))};
    end
    pool[0] = {8'd0, 8'($urandom_range(0, 3))};
    repeat (n_beats) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        op = 2'($urandom);
        id = 16'($urandom);
      end else if (pick < 12) begin
        op = 2'($urandom);
        id = {8'($urandom_range(NUM_REGS_DEF - 1, NUM_REGS_DEF)),
              8'($urandom_range(BITS_PER_REG_DEF - 2, BITS_PER_REG_DEF + 1))};
      end else begin
        id = pool[$urandom_range(0, 5)];
        pick = $urandom_range(99);
        if (pick < 45) op = OP_ENABLE;
        else if (pick < 85) op = OP_DISABLE;
        else if (pick < 95) op = OP_QUERY;
        else op = OP_UNUSED;
      end
      send_beat(op, id);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    gate_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending, status", 32'(status_o), 32'd0);
      end else begin
        want = pending_results.pop_front();
        case (want.status)
          ST_OK:        n_ok++;
          ST_BAD_ID:    n_bad_id++;
          default:      n_bad_state++;
        endcase
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (use_count_o !== want.use_count)
          report_mismatch("use_count", 32'(use_count_o), 32'(want.use_count));
        if (stopped_o !== want.stopped)
          report_mismatch("stopped", 32'(stopped_o), 32'(want.stopped));
        if (stop_word_o !== want.stop_word)
          report_mismatch("stop_word", stop_word_o, want.stop_word);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", QUIET_LIMIT);
      $display("refcounted_module_clock_gate verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    operation_i <= OP_QUERY;
    id_i <= '0;
    for (int i = 0; i < NUM_SLOTS; i++) model_counts[i] = '0;
    for (int i = 0; i < NUM_REGS_DEF; i++) begin
      model_stop_words[i] = (i == 0) ? WORD0_RESET : WORD_RESET;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 34;
    test_directed();
    test_saturation();
    test_random_traffic(300);
    idle_pct = 65;
    test_random_traffic(300);
    idle_pct = 0;
    test_random_traffic(300);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d request beats: directed cases, both count limits, random traffic.",
             beats_sent);
    $display("Checked %0d results: %0d ok, %0d invalid id, %0d invalid state.",
             results_seen, n_ok, n_bad_id, n_bad_state);
    if (errors == 0) begin
      $display("refcounted_module_clock_gate verification clean");
    end else begin
      $display("refcounted_module_clock_gate verification failed");
    end
    $finish;
  end

endmodule
